// File: rtl/dnp_pkg.sv
package dnp_pkg;

    typedef enum logic [1:0] {
        PH_LEN   = 2'd0,
        PH_LABEL = 2'd1,
        PH_PTR   = 2'd2,
        PH_DONE  = 2'd3
    } t_phase;

    localparam int unsigned LEFT_W = 6;
    localparam logic [7:0] PTR_MASK = 8'hC0;

    localparam int unsigned POS_W   = 9;
    localparam int unsigned NLEN_W  = 9;
    localparam int unsigned LTOT_W  = 8;

endpackage

// File: rtl/dnp_byte_if.sv
interface dnp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] name_byte;
    logic       last;

    modport source (output valid, output name_byte, output last, input ready);
    modport sink   (input valid, input name_byte, input last, output ready);
endinterface

// File: rtl/dnp_result_if.sv
interface dnp_result_if;
    logic       valid;
    logic       ready;
    logic [8:0] label_position;
    logic       is_final;
    logic       status;
    logic [8:0] name_length;
    logic [7:0] label_total;

    modport source (
        output valid, output label_position, output is_final, output status,
        output name_length, output label_total, input ready
    );
    modport sink (
        input valid, input label_position, input is_final, input status,
        input name_length, input label_total, output ready
    );
endinterface

// File: rtl/dnp_cfg_if.sv
interface dnp_cfg_if;
    logic valid;
    logic ready;
    logic label_mode;

    modport source (output valid, output label_mode, input ready);
    modport sink   (input valid, input label_mode, output ready);
endinterface

// File: rtl/dns_name_wire_parser_core.sv
// An item is registered on acceptance and its result, if any, is registered
// in the output stage as the item leaves the input register; a stalled result holds the item.
// Throughput: one item per cycle while the result output is not stalled.
// Reset is synchronous and active low; it clears the parse state, the valid
// flags of both stages and the label mode register.
module dns_name_wire_parser_core #(
    parameter int unsigned MAX_LABEL_BYTES = 63,
    parameter int unsigned MAX_NAME_BYTES  = 256
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    dnp_byte_if.sink     i_byte,
    dnp_cfg_if.sink      i_cfg,
    dnp_result_if.source o_result
);
    import dnp_pkg::*;

    localparam int unsigned IW = $clog2(MAX_NAME_BYTES + 3);
    localparam int unsigned CW = $clog2(MAX_NAME_BYTES / 2 + 2);
    localparam int unsigned SW = ((IW > 8) ? IW : 8) + 1;

    logic             r_mode;
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;
    t_phase           r_phase;
    logic [LEFT_W-1:0] r_left;
    logic [IW-1:0]    r_index;
    logic [CW-1:0]    r_labels;

    t_phase           n_phase;
    logic [LEFT_W-1:0] n_left;
    logic [IW-1:0]    n_index;
    logic [CW-1:0]    n_labels;

    logic             r_out_valid;
    logic [POS_W-1:0] r_out_pos;
    logic             r_out_fin;
    logic             r_out_err;
    logic [NLEN_W-1:0] r_out_nlen;
    logic [LTOT_W-1:0] r_out_ltot;

    logic             s2_go;
    logic             is_ptr;
    logic             b_zero;
    logic             too_long;
    logic [IW-1:0]    next_index;
    logic [SW-1:0]    label_end;
    logic             emit;
    logic             fin;
    logic             err;
    logic [POS_W-1:0] pos;
    logic [NLEN_W-1:0] nlen;
    logic [LTOT_W-1:0] ltot;

    assign s2_go        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_byte.ready = !r_in_valid || s2_go;
    assign i_cfg.ready  = 1'b1;

    assign is_ptr     = (r_in_byte & PTR_MASK) == PTR_MASK;
    assign b_zero     = r_in_byte == 8'd0;
    assign next_index = r_index + IW'(1);
    assign label_end  = SW'(next_index) + SW'(r_in_byte);
    assign too_long   = (r_in_byte > 8'(MAX_LABEL_BYTES))
                     || (label_end > SW'(MAX_NAME_BYTES));

    // Next parse state.
    always_comb begin
        n_phase  = r_phase;
        n_left   = r_left;
        n_index  = r_index;
        n_labels = r_labels;
        case (r_phase)
            PH_LEN: begin
                n_index = next_index;
                if (r_mode) begin
                    n_labels = r_labels + CW'(1);
                    if (b_zero || too_long) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_left  = r_in_byte[LEFT_W-1:0];
                        n_phase = PH_LABEL;
                    end
                end else if (is_ptr) begin
                    n_phase = PH_PTR;
                end else if (b_zero || too_long) begin
                    n_phase = PH_DONE;
                end else begin
                    n_left  = r_in_byte[LEFT_W-1:0];
                    n_phase = PH_LABEL;
                end
            end
            PH_LABEL: begin
                n_index = next_index;
                n_left  = r_left - LEFT_W'(1);
                if (r_left == LEFT_W'(1)) begin
                    n_phase = PH_LEN;
                end
            end
            PH_PTR: begin
                n_index = next_index;
                n_phase = PH_DONE;
            end
            default: begin
            end
        endcase
        if (r_in_last) begin
            n_phase  = PH_LEN;
            n_left   = '0;
            n_index  = '0;
            n_labels = '0;
        end
    end

    // Result of the current item.
    always_comb begin
        emit = 1'b0;
        fin  = 1'b0;
        err  = 1'b0;
        pos  = '0;
        nlen = '0;
        ltot = '0;
        case (r_phase)
            PH_LEN: begin
                if (r_mode) begin
                    emit = 1'b1;
                    pos  = POS_W'(r_index);
                    if (b_zero) begin
                        fin  = 1'b1;
                        nlen = NLEN_W'(next_index);
                        ltot = LTOT_W'(r_labels + CW'(1));
                    end else if (too_long) begin
                        fin = 1'b1;
                        err = 1'b1;
                    end
                end else if (!is_ptr) begin
                    if (b_zero) begin
                        emit = 1'b1;
                        fin  = 1'b1;
                        nlen = NLEN_W'(next_index);
                    end else if (too_long) begin
                        emit = 1'b1;
                        fin  = 1'b1;
                        err  = 1'b1;
                    end
                end
            end
            PH_PTR: begin
                emit = 1'b1;
                fin  = 1'b1;
                nlen = NLEN_W'(next_index);
            end
            default: begin
            end
        endcase
        if (r_in_last && !fin && r_phase != PH_DONE && r_phase != PH_PTR) begin
            emit = 1'b1;
            fin  = 1'b1;
            err  = 1'b1;
        end
        if (err) begin
            nlen = '0;
            ltot = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_in_valid  <= 1'b0;
            r_phase     <= PH_LEN;
            r_left      <= '0;
            r_index     <= '0;
            r_labels    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_mode <= i_cfg.label_mode;
            end
            if (i_byte.ready) begin
                r_in_valid <= i_byte.valid;
            end
            if (s2_go) begin
                r_phase  <= n_phase;
                r_left   <= n_left;
                r_index  <= n_index;
                r_labels <= n_labels;
            end
            if (s2_go && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.name_byte;
            r_in_last <= i_byte.last;
        end
        if (s2_go && emit) begin
            r_out_pos  <= pos;
            r_out_fin  <= fin;
            r_out_err  <= err;
            r_out_nlen <= nlen;
            r_out_ltot <= ltot;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.label_position = r_out_pos;
    assign o_result.is_final       = r_out_fin;
    assign o_result.status         = r_out_err;
    assign o_result.name_length    = r_out_nlen;
    assign o_result.label_total    = r_out_ltot;

    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_LABEL |-> r_left != '0)
        else $error("Label phase entered with no label bytes left.");

    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_index <= IW'(MAX_NAME_BYTES + 2))
        else $error("Byte offset ran past the name limit.");

    a_error_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_err |-> r_out_fin && r_out_nlen == '0 && r_out_ltot == '0)
        else $error("Error result is not a final result with cleared counts.");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_go && r_in_last |=> r_phase == PH_LEN && r_index == '0 && r_labels == '0)
        else $error("Parse state not cleared after the last item of a buffer.");

    a_last_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_go && r_in_last && r_phase != PH_DONE |=> r_out_valid && r_out_fin)
        else $error("Buffer ended without a final result.");

endmodule
